// ===== hw/rtl/sum7_frame_deframer_macros.svh =====
// Assertion macros for the sum7 frame deframer.
`ifndef SUM7_FRAME_DEFRAMER_MACROS_SVH
`define SUM7_FRAME_DEFRAMER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define S7FD_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Check an implication in the cycle after its condition, outside reset.
`define S7FD_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== hw/rtl/s7fd_pkg.sv =====
// Types and constants for the sum7 frame deframer.
`default_nettype none

package s7fd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 7;
  localparam int unsigned POS_W  = 9;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFE;
  localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_LENGTH  = 8'd3;
  localparam logic [POS_W-1:0]  SHORT_LIMIT = 9'd6;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_HEADER   = 3'd3,
    ST_TAIL     = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sum7_frame_deframer.sv =====
// Sum7 frame deframer: takes one received byte per cycle, streams data bytes
// out and gives one status report at the end of each frame. A byte is taken on
// every clock while the result register is empty or being drained, so the
// sustained rate is one byte per cycle; each result appears in the cycle after
// its byte is taken, from the result register. The block stalls input only while a
// result waits in that register with out_ready low.
`default_nettype none
`include "sum7_frame_deframer_macros.svh"

module sum7_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       buffer_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      payload_byte,
  output logic [7:0]      destination,
  output logic [7:0]      command_code,
  output logic [7:0]      subcommand_code,
  output logic [7:0]      length_field,
  output logic [2:0]      frame_status
);

  logic [s7fd_pkg::POS_W-1:0]  byte_position, pos_next;
  logic [s7fd_pkg::SUM_W-1:0]  running_sum, sum_next;
  logic [s7fd_pkg::BYTE_W-1:0] held_length, len_next;
  logic [s7fd_pkg::BYTE_W-1:0] held_destination, dst_next;
  logic [s7fd_pkg::BYTE_W-1:0] held_command, cmd_next;
  logic [s7fd_pkg::BYTE_W-1:0] held_subcommand, sub_next;
  logic                        header_good, header_good_next;
  logic                        skip_rest, skip_rest_next;

  logic                        in_fire;
  logic                        report;
  logic                        data_hit;
  logic                        emit;
  s7fd_pkg::status_t           status;
  logic [s7fd_pkg::POS_W-1:0]  len_ext;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign len_ext  = {1'b0, held_length};

  always_comb begin
    pos_next         = byte_position;
    sum_next         = running_sum;
    len_next         = held_length;
    dst_next         = held_destination;
    cmd_next         = held_command;
    sub_next         = held_subcommand;
    header_good_next = header_good;
    skip_rest_next   = skip_rest;
    report           = 1'b0;
    data_hit         = 1'b0;
    status           = s7fd_pkg::ST_OK;
    emit             = 1'b0;

    if (skip_rest) begin
      if (buffer_end) begin
        skip_rest_next = 1'b0;
      end
    end else begin
      if (byte_position == '0) begin
        len_next         = '0;
        dst_next         = '0;
        cmd_next         = '0;
        sub_next         = '0;
        header_good_next = (rx_byte == s7fd_pkg::HEADER_BYTE);
        sum_next         = rx_byte[s7fd_pkg::SUM_W-1:0];
      end else if (byte_position == 9'd1) begin
        len_next = rx_byte;
        sum_next = running_sum + rx_byte[s7fd_pkg::SUM_W-1:0];
        if (rx_byte < s7fd_pkg::MIN_LENGTH) begin
          report = 1'b1;
          status = s7fd_pkg::ST_SHORT;
        end
      end else if (byte_position <= len_ext + 9'd1) begin
        sum_next = running_sum + rx_byte[s7fd_pkg::SUM_W-1:0];
        if (byte_position == 9'd2) begin
          dst_next = rx_byte;
        end else if (byte_position == 9'd3) begin
          cmd_next = rx_byte;
        end else if (byte_position == 9'd4) begin
          sub_next = rx_byte;
        end else begin
          data_hit = 1'b1;
        end
      end else if (byte_position == len_ext + 9'd2) begin
        if (buffer_end && byte_position < s7fd_pkg::SHORT_LIMIT) begin
          report = 1'b1;
          status = s7fd_pkg::ST_SHORT;
        end else if (rx_byte != {1'b0, running_sum}) begin
          report = 1'b1;
          status = s7fd_pkg::ST_CHECKSUM;
        end else if (buffer_end) begin
          report = 1'b1;
          status = header_good ? s7fd_pkg::ST_TRUNC : s7fd_pkg::ST_HEADER;
        end
      end else begin
        report = 1'b1;
        if (!header_good) begin
          status = s7fd_pkg::ST_HEADER;
        end else if (rx_byte != s7fd_pkg::TAIL_BYTE) begin
          status = s7fd_pkg::ST_TAIL;
        end else begin
          status = s7fd_pkg::ST_OK;
        end
      end

      if (!report && buffer_end) begin
        report = 1'b1;
        status = (byte_position < s7fd_pkg::SHORT_LIMIT) ? s7fd_pkg::ST_SHORT
                                                         : s7fd_pkg::ST_TRUNC;
      end

      if (report) begin
        pos_next = '0;
        sum_next = '0;
        if (status != s7fd_pkg::ST_OK && !buffer_end) begin
          skip_rest_next = 1'b1;
        end
      end else begin
        pos_next = byte_position + 9'd1;
      end

      emit = report || data_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      running_sum      <= '0;
      held_length      <= '0;
      held_destination <= '0;
      held_command     <= '0;
      held_subcommand  <= '0;
      header_good      <= 1'b0;
      skip_rest        <= 1'b0;
    end else if (in_fire) begin
      byte_position    <= pos_next;
      running_sum      <= sum_next;
      held_length      <= len_next;
      held_destination <= dst_next;
      held_command     <= cmd_next;
      held_subcommand  <= sub_next;
      header_good      <= header_good_next;
      skip_rest        <= skip_rest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind            <= report;
      payload_byte    <= report ? 8'd0 : rx_byte;
      destination     <= dst_next;
      command_code    <= cmd_next;
      subcommand_code <= sub_next;
      length_field    <= len_next;
      frame_status    <= report ? status : s7fd_pkg::ST_OK;
    end
  end

  `S7FD_ASSERT_IMPL(a_pos_bound, 1'b1, byte_position <= len_ext + 9'd3 || byte_position <= 9'd1, "byte position past frame tail")
  `S7FD_ASSERT_IMPL(a_data_clean, out_valid && !kind, frame_status == s7fd_pkg::ST_OK, "data transfer carries a status")
  `S7FD_ASSERT_NEXT(a_buf_end, in_fire && buffer_end, byte_position == '0 && !skip_rest, "buffer end did not restart framing")
  `S7FD_ASSERT_NEXT(a_err_skip, in_fire && !skip_rest && report && status != s7fd_pkg::ST_OK && !buffer_end, skip_rest, "error did not start skipping")

endmodule

`default_nettype wire
